[hdl/gfmi_pkg.sv]
// gfmi_pkg: types, constants and helpers shared by the gf(2^n) multiply/inverse unit
// depends on nothing; every other file imports it
`default_nettype none

package gfmi_pkg;

	localparam int DATA_W      = 8;   // field element width
	localparam int POLY_W      = 9;   // field polynomial width, top term included
	localparam int DEG_W       = 4;   // holds a degree 0..8
	localparam int STATUS_W    = 2;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int MAX_DEGREE_DEF = 8;

	localparam logic [POLY_W-1:0] RESET_POLY = 9'h013;

	// register index as seen on paddr above the byte offset
	localparam logic [APB_ADDR_W-3:0] REG_FIELD_POLY = 1'b0;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_INV = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_INV_ZERO = 2'd1,
		ST_BAD_POLY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_INV,
		S_DONE
	} state_t;

	// field description handed to the step unit
	typedef struct packed {
		logic [POLY_W-1:0] poly;
		logic [DEG_W-1:0]  deg;
		logic [DATA_W-1:0] mask;
	} field_t;

	// working registers of one item
	// multiply: r partial product, u accumulator, v remaining bits of b
	// inverse: s, r remainders, v, u cofactors
	typedef struct packed {
		logic [POLY_W-1:0] s;
		logic [POLY_W-1:0] r;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] u;
	} work_t;

	// index of the highest set bit, zero for zero and one
	function automatic logic [DEG_W-1:0] degree(input logic [POLY_W-1:0] p);
		logic [DEG_W-1:0] d;
		d = '0;
		for (int i = 1; i < POLY_W; i++) begin
			if (p[i]) d = DEG_W'(i);
		end
		return d;
	endfunction

	function automatic logic [DATA_W-1:0] mask_of(input logic [DEG_W-1:0] n);
		logic [POLY_W-1:0] m;
		m = (POLY_W'(1) << n) - POLY_W'(1);
		return m[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/gfmi_if.sv]
// gfmi_req_if / gfmi_rsp_if: valid-ready channels of the multiply/inverse unit
// depends on gfmi_pkg
`default_nettype none

interface gfmi_req_if import gfmi_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [0:0]        opcode;
	logic [DATA_W-1:0] operand_a;
	logic [DATA_W-1:0] operand_b;

	modport source (output valid, opcode, operand_a, operand_b, input ready);
	modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface gfmi_rsp_if import gfmi_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   result_value;
	logic [STATUS_W-1:0] status;

	modport source (output valid, result_value, status, input ready);
	modport sink   (input valid, result_value, status, output ready);
endinterface

`default_nettype wire

[hdl/gfmi_alu.sv]
// gfmi_alu: shared step unit, one multiply step or one euclid iteration per call
// depends on gfmi_pkg
`default_nettype none

module gfmi_alu import gfmi_pkg::*; (
	input  wire op_t    mode,
	input  wire field_t fld,
	input  wire work_t  cur,
	output work_t       nxt,
	output logic        r_is_const
);

	always_comb begin
		logic [DEG_W-1:0]  ds;
		logic [DEG_W-1:0]  dr;
		logic [DEG_W-1:0]  sh;
		logic [POLY_W-1:0] tx;
		work_t             sw;
		ds = degree(cur.s);
		dr = degree(cur.r);
		r_is_const = (dr == '0);
		sw = cur;
		sh = '0;
		tx = '0;
		nxt = cur;
		case (mode)
			OP_MUL: begin
				// add partial product, then partial times x mod poly
				nxt.u = cur.u ^ (cur.v[0] ? cur.r[DATA_W-1:0] : '0);
				tx = {cur.r[DATA_W-1:0], 1'b0};
				if (cur.r[fld.deg - DEG_W'(1)]) tx = tx ^ fld.poly;
				nxt.r = {1'b0, tx[DATA_W-1:0] & fld.mask};
				nxt.v = cur.v >> 1;
			end
			OP_INV: begin
				if (ds < dr) begin
					sw.s = cur.r;
					sw.r = cur.s;
					sw.v = cur.u;
					sw.u = cur.v;
					sh = dr - ds;
				end else begin
					sh = ds - dr;
				end
				nxt = sw;
				// cancel the top term of s
				nxt.s = sw.s ^ (sw.r << sh);
				nxt.v = sw.v ^ (sw.u << sh);
			end
			default: nxt = cur;
		endcase
	end

endmodule

`default_nettype wire

[hdl/gf2m_multiply_inverse_unit.sv]
// gf2m_multiply_inverse_unit: top level, apb register, sequencer and output register
// depends on gfmi_pkg, gfmi_if and gfmi_alu
`default_nettype none

// Multiplies or inverts elements of GF(2^n), n being the degree of the polynomial written
// to field_polynomial (byte address 0, reset 0x13, i.e. x^4+x+1). One request item
// gives one response item. A single step unit does all arithmetic under a small sequencer,
// one step per clock: multiply takes n steps (shift-and-add over the bits of operand_b),
// inverse takes one step per binary extended Euclid iteration, at most 2n. An item passes
// through the accept, its steps, the loop exit check and the output load; items with a
// nonzero status go from the accept straight to the output load. The request side is
// not ready while an item is in work. The result sits in an output register, so the next
// item is accepted while the last response still waits; a finished item waits in place
// until that register is free. Status 1 means inverse of zero, status 2 a polynomial of
// degree below two or above MAX_DEGREE; in both cases result_value is zero. With a
// reducible polynomial the loop runs as usual and returns its final cofactor. The
// polynomial is to be written only while the unit is idle; the unit does not enforce this.

module gf2m_multiply_inverse_unit import gfmi_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// apb register port
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [APB_ADDR_W-1:0] paddr,
	input  wire  [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// item channels
	gfmi_req_if.sink              req,
	gfmi_rsp_if.source            rsp
);

	// iteration guard of the euclid loop, never reached with a sane degree
	localparam int GUARD_LIMIT = 2 * MAX_DEGREE + 4;
	localparam int CNT_W       = $clog2(GUARD_LIMIT + 1);

	state_t              state_q, state_d;
	logic [POLY_W-1:0]   poly_q;
	work_t               work_q, work_nxt;
	field_t              fld_q;
	logic [CNT_W-1:0]    cnt_q;
	status_t             st_q;
	logic                out_vld_q;
	logic [DATA_W-1:0]   out_val_q;
	status_t             out_st_q;

	logic                start;     // item taken this cycle
	logic                step;      // step unit result written back
	logic                load_out;  // result moves into the output register
	logic                r_is_const;
	op_t                 mode;

	// start-of-item decode
	logic [DEG_W-1:0]    deg_w;
	logic [DATA_W-1:0]   mask_w;
	logic [DATA_W-1:0]   a_m;
	logic [DATA_W-1:0]   b_m;
	logic                bad_poly;

	// register port
	assign pready = 1'b1;
	assign prdata = {{(APB_DATA_W - POLY_W){1'b0}}, poly_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= RESET_POLY;
		end else if (psel && penable && pwrite
				&& paddr[APB_ADDR_W-1:2] == REG_FIELD_POLY) begin
			poly_q <= pwdata[POLY_W-1:0];
		end
	end

	assign deg_w    = degree(poly_q);
	assign mask_w   = mask_of(deg_w);
	assign a_m      = req.operand_a & mask_w;
	assign b_m      = req.operand_b & mask_w;
	assign bad_poly = (deg_w < DEG_W'(2)) || (int'(deg_w) > MAX_DEGREE);

	assign mode = (state_q == S_INV) ? OP_INV : OP_MUL;

	gfmi_alu u_alu (
		.mode       (mode),
		.fld        (fld_q),
		.cur        (work_q),
		.nxt        (work_nxt),
		.r_is_const (r_is_const)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		start     = 1'b0;
		step      = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					start = 1'b1;
					if (bad_poly) begin
						state_d = S_DONE;
					end else if (op_t'(req.opcode) == OP_MUL) begin
						state_d = S_MUL;
					end else if (a_m == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_INV;
					end
				end
			end
			S_MUL: begin
				if (cnt_q == '0) state_d = S_DONE;
				else step = 1'b1;
			end
			S_INV: begin
				// loop ends once the remainder is a constant or the iteration guard is reached
				if (r_is_const || cnt_q == CNT_W'(GUARD_LIMIT)) state_d = S_DONE;
				else step = 1'b1;
			end
			S_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			st_q  <= ST_OK;
		end else if (start) begin
			if (bad_poly) begin
				st_q <= ST_BAD_POLY;
			end else if (op_t'(req.opcode) == OP_INV && a_m == '0) begin
				st_q <= ST_INV_ZERO;
			end else begin
				st_q <= ST_OK;
			end
			// multiply counts down the bits of b, inverse counts iterations up
			cnt_q <= (op_t'(req.opcode) == OP_MUL) ? CNT_W'(deg_w) : '0;
		end else if (step) begin
			cnt_q <= (state_q == S_MUL) ? cnt_q - CNT_W'(1) : cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fld_q.poly <= poly_q;
			fld_q.deg  <= deg_w;
			fld_q.mask <= mask_w;
			if (op_t'(req.opcode) == OP_MUL) begin
				work_q.s <= '0;
				work_q.r <= {1'b0, a_m};
				work_q.v <= b_m;
				work_q.u <= '0;
			end else begin
				work_q.s <= poly_q;
				work_q.r <= {1'b0, a_m};
				work_q.v <= '0;
				work_q.u <= DATA_W'(1);
			end
		end else if (step) begin
			work_q <= work_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_val_q <= (st_q == ST_OK) ? (work_q.u & fld_q.mask) : '0;
			out_st_q  <= st_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.result_value = out_val_q;
	assign rsp.status       = out_st_q;

	// checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> rsp.result_value == '0)
		else $error("nonzero status with nonzero result");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while an item is in work");

	a_guard_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INV) |-> cnt_q <= CNT_W'(GUARD_LIMIT))
		else $error("euclid iteration count past its guard");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_vld_q) |=> (out_vld_q && state_q == S_IDLE))
		else $error("finished item not moved to the output register");

endmodule

`default_nettype wire

[tb/sv/gf2m_result_checker.sv]
// gf2m_result_checker: watches the register port and both item channels of the
// gf(2^n) multiply/inverse unit, predicts every result and compares it in order
// depends on gfmi_pkg and gfmi_if
`default_nettype none

module gf2m_result_checker import gfmi_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire [APB_ADDR_W-1:0] paddr,
	input  wire [APB_DATA_W-1:0] pwdata,
	input  wire                  pready,
	gfmi_req_if                  req,
	gfmi_rsp_if                  rsp,
	output int unsigned          fail_count,
	output int unsigned          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] value;
		status_t           status;
	} gf_expect_t;

	gf_expect_t        expected_results[$];
	gf_expect_t        oldest;
	logic [POLY_W-1:0] field_poly;

	// highest set bit, zero for zero and one
	function automatic int unsigned top_bit(input logic [15:0] p);
		int unsigned d;
		d = 0;
		for (int i = 1; i < 16; i++) begin
			if (p[i]) d = i;
		end
		return d;
	endfunction

	function automatic gf_expect_t field_result(input op_t op, input logic [DATA_W-1:0] a_in,
			input logic [DATA_W-1:0] b_in, input logic [POLY_W-1:0] poly);
		gf_expect_t  res;
		int unsigned n, ds, dr, sh;
		logic [DATA_W-1:0] mask, a, b;
		logic [15:0] part, acc, t, s, r, v, u;
		res.op = op;
		res.a = a_in;
		res.b = b_in;
		res.value = '0;
		res.status = ST_OK;
		n = top_bit({7'd0, poly});
		if (n < 2 || n > MAX_DEGREE) begin
			res.status = ST_BAD_POLY;
			return res;
		end
		mask = DATA_W'((16'd1 << n) - 16'd1);
		a = a_in & mask;
		b = b_in & mask;
		if (op == OP_MUL) begin
			// shift-and-add, one bit of b per step
			acc = '0;
			part = {8'd0, a};
			for (int i = 0; i < n; i++) begin
				if (b[i]) acc ^= part;
				t = (part << 1) & 16'h03FF;
				if (part[n-1]) t ^= {7'd0, poly};
				part = t & {8'd0, mask};
			end
			res.value = acc[DATA_W-1:0] & mask;
		end else if (a == '0) begin
			res.status = ST_INV_ZERO;
		end else begin
			// binary extended euclid on (poly, a), cofactors (0, 1)
			s = {7'd0, poly};
			r = {8'd0, a};
			v = '0;
			u = 16'd1;
			for (int g = 0; g < 2 * MAX_DEGREE + 4; g++) begin
				if (top_bit(r) == 0) break;
				ds = top_bit(s);
				dr = top_bit(r);
				if (ds < dr) begin
					t = s; s = r; r = t;
					t = v; v = u; u = t;
					sh = dr - ds;
				end else begin
					sh = ds - dr;
				end
				s = s ^ (r << sh);
				v = v ^ (u << sh);
			end
			res.value = u[DATA_W-1:0] & mask;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns check: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			field_poly = RESET_POLY;
			fail_count = 0;
			pending <= 0;
		end else begin
			// accepted items use the polynomial in force before this edge
			if (req.valid && req.ready)
				expected_results.push_back(field_result(op_t'(req.opcode), req.operand_a,
					req.operand_b, field_poly));
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result item with none expected: value %0h status %0d",
						rsp.result_value, rsp.status));
				end else begin
					oldest = expected_results.pop_front();
					if (rsp.result_value !== oldest.value)
						report_mismatch($sformatf("%s a=%0h b=%0h poly=%0h: value %0h, expected %0h",
							oldest.op.name(), oldest.a, oldest.b, field_poly, rsp.result_value,
							oldest.value));
					if (rsp.status !== oldest.status)
						report_mismatch($sformatf("%s a=%0h b=%0h poly=%0h: status %0d, expected %0d",
							oldest.op.name(), oldest.a, oldest.b, field_poly, rsp.status,
							oldest.status));
				end
			end
			if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_FIELD_POLY)
				field_poly = pwdata[POLY_W-1:0];
			pending <= expected_results.size();
		end
	end

endmodule

`default_nettype wire

[tb/sv/gf2m_multiply_inverse_unit_tb.sv]
// gf2m_multiply_inverse_unit_tb: clock, reset, register writes and item traffic for the
// gf(2^n) multiply/inverse unit; checking is left to gf2m_result_checker
// depends on gfmi_pkg, gfmi_if, gf2m_result_checker and the unit itself
`default_nettype none

module gf2m_multiply_inverse_unit_tb import gfmi_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CYCLE_LIMIT     = 400000;
	localparam int          MAX_GAP         = 18;
	localparam int          HOLD_CYCLES     = 500;
	localparam int          DRAIN_CYCLES    = 40;
	localparam int          ITEMS_PER_PHASE = 100;
	localparam int          NUM_PHASES      = 14;
	// second word of the register window, not backed by any register
	localparam logic [APB_ADDR_W-3:0] REG_UNUSED = 1'b1;

	// polynomials of the random phases: both extremes, every degree that gives a
	// usable field, unusable degrees, and reducible ones
	localparam logic [POLY_W-1:0] PHASE_POLY [NUM_PHASES] = '{
		9'h013, 9'h11B, 9'h1FF, 9'h000, 9'h007, 9'h004, 9'h00B,
		9'h025, 9'h043, 9'h083, 9'h100, 9'h11D, 9'h002, 9'h001
	};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycle_count;

	// idling switches, redrawn every 25 items of a phase so that stretches without gaps occur
	bit req_idle;
	bit rsp_idle;
	// long receiver stall, raised by its own process
	bit rsp_hold;

	gfmi_req_if req_ch ();
	gfmi_rsp_if rsp_ch ();

	gf2m_multiply_inverse_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	gf2m_result_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// setup cycle, then access cycle; the register takes the data at the access edge
	task automatic apb_write(input logic [APB_ADDR_W-3:0] idx, input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// offer one item after a random gap and return at the edge that accepts it;
	// with no gap, valid simply stays high for the next item
	task automatic send_item(input op_t op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		int unsigned gap;
		gap = req_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= op;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// drop valid and wait until every expected result has been taken
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// operands lean toward zero, one, all ones and single bits
	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
			3:       return DATA_W'(1);
			default: return DATA_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic hold_responses();
		rsp_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold = 1'b0;
	endtask

	// watchdog: ends the run if the traffic never drains
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// receiver: a random stall per item, or none, and the long hold when raised
	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (stall != 0 || rsp_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (rsp_hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	initial begin
		// every input known from time zero
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = OP_MUL;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;
		req_idle         = 1'b1;
		rsp_idle         = 1'b1;
		rsp_hold         = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items on the reset polynomial x^4+x+1, never written
		send_item(OP_MUL, 8'h00, 8'h00);
		send_item(OP_MUL, 8'hFF, 8'hFF);   // upper operand bits dropped
		send_item(OP_MUL, 8'h08, 8'h02);   // reduction on the top bit
		send_item(OP_MUL, 8'h0F, 8'h01);
		send_item(OP_INV, 8'h00, 8'hFF);   // inverse of zero
		send_item(OP_INV, 8'hF0, 8'h00);   // zero once masked
		send_item(OP_INV, 8'h01, 8'hAA);   // b ignored on inverse
		send_item(OP_INV, 8'hFF, 8'h55);
		send_item(OP_INV, 8'h0E, 8'hFF);
		wait_idle();

		// aes field, widest usable degree
		apb_write(REG_FIELD_POLY, 32'h0000_011B);
		send_item(OP_MUL, 8'hFF, 8'hFF);
		send_item(OP_MUL, 8'h80, 8'h02);
		send_item(OP_INV, 8'h53, 8'h00);
		send_item(OP_INV, 8'h80, 8'hFF);
		send_item(OP_INV, 8'h00, 8'h00);
		wait_idle();

		// polynomial zero: unusable for both operations
		apb_write(REG_FIELD_POLY, 32'h0000_0000);
		send_item(OP_MUL, 8'hFF, 8'hFF);
		send_item(OP_INV, 8'h01, 8'h00);
		wait_idle();

		// degree one: still unusable
		apb_write(REG_FIELD_POLY, 32'h0000_0003);
		send_item(OP_INV, 8'h01, 8'h01);
		send_item(OP_MUL, 8'h01, 8'h01);
		wait_idle();

		// all ones, reducible: the loop runs anyway
		apb_write(REG_FIELD_POLY, 32'hFFFF_FFFF);
		send_item(OP_INV, 8'h03, 8'h00);
		send_item(OP_INV, 8'hFF, 8'h00);
		send_item(OP_MUL, 8'hC3, 8'h7E);

		// random phases, one polynomial each; upper write data bits are noise
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			apb_write(REG_FIELD_POLY, ($urandom & ~32'h1FF) | APB_DATA_W'(PHASE_POLY[p]));
			// writes to the empty word must not disturb the polynomial
			if (p % 4 == 1) apb_write(REG_UNUSED, $urandom);
			// long receiver stall on a slow field, so the unit backs up
			if (p == 2) begin
				fork
					hold_responses();
				join_none
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % 25 == 0) begin
					req_idle = ($urandom_range(0, 3) != 0);
					rsp_idle = ($urandom_range(0, 3) != 0);
				end
				send_item(op_t'($urandom_range(0, 1)), pick_operand(), pick_operand());
			end
		end

		// drain, then leave room for any stray result
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
hdl/gfmi_pkg.sv
hdl/gfmi_if.sv
hdl/gfmi_alu.sv
hdl/gf2m_multiply_inverse_unit.sv
tb/sv/gf2m_result_checker.sv
tb/sv/gf2m_multiply_inverse_unit_tb.sv
